// ===== sv/dqe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dqe_pkg;

    localparam int DQE_DEPTH      = 256;
    localparam int DQE_DATA_WIDTH = 32;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_REAR   = 3'd3;
    localparam logic [2:0] OP_READ_IDX   = 3'd4;
    localparam logic [2:0] OP_WRITE_IDX  = 3'd5;
    localparam logic [2:0] OP_CLEAR      = 3'd6;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_RANGE = 2'd3;

    localparam logic [31:0] NEG_ONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic [7:0]         index;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic signed [31:0] front_value;
        logic signed [31:0] rear_value;
        logic [8:0]         count;
        logic               is_empty;
    } out_t;

endpackage

`default_nettype wire

// ===== sv/dqe_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dqe_ram
    import dqe_pkg::*;
#(
    parameter int DEPTH      = DQE_DEPTH,
    parameter int DATA_WIDTH = DQE_DATA_WIDTH,
    localparam int AW        = $clog2(DEPTH)
)
(
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [DATA_WIDTH-1:0] wdata,
    input  wire logic                  re,
    input  wire logic [AW-1:0]         raddr,
    output logic [DATA_WIDTH-1:0]      rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/double_ended_queue_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue held in a ring buffer (one synchronous RAM).
// Commands: a beat on req is taken at the rising edge where start is high and
// busy is low. Each command gives exactly one response beat on rsp, marked by
// done for one cycle; the receiver cannot hold it off.
// Push, write at index, clear, an unknown op code and every failing command
// answer in the cycle after the command beat, and busy stays low. Read at
// index, and a pop that leaves at least one element, go through the wait
// state: the registered RAM read fetches the element or the new front or
// rear element, which is cached in registers so that every response reports
// front and rear without a further access; busy is high during the wait.
// The RAM has one write and one read port; a command never reads and writes
// the same edge, so no forwarding is needed.
// Reset clears the head position and the fill count; the RAM keeps its
// contents, and only entries below the fill count are ever read.
// A new command may be taken in the same cycle that a response is shown.
module double_ended_queue_engine_top
    import dqe_pkg::*;
#(
    parameter int DEPTH      = DQE_DEPTH,
    parameter int DATA_WIDTH = DQE_DATA_WIDTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire in_t  req,
    output logic      done,
    output out_t      rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic STATE_IDLE = 1'b0;
    localparam logic STATE_WAIT = 1'b1;

    localparam logic [1:0] PEND_FRONT = 2'd0;
    localparam logic [1:0] PEND_REAR  = 2'd1;
    localparam logic [1:0] PEND_READ  = 2'd2;

    function automatic logic [AW-1:0] phys(logic [AW-1:0] head, logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW + 1)'(head) + (CW + 1)'(off);
        if (sum >= (CW + 1)'(DEPTH))
        begin
            sum = sum - (CW + 1)'(DEPTH);
        end
        return AW'(sum);
    endfunction

    function automatic logic [31:0] report(logic [DATA_WIDTH-1:0] w);
        logic signed [63:0] ext;
        ext = 64'(signed'(w));
        return ext[31:0];
    endfunction

    function automatic logic [DATA_WIDTH-1:0] store(logic [31:0] v);
        return DATA_WIDTH'({32'd0, v});
    endfunction

    function automatic out_t mk_rsp(logic [1:0] status, logic [31:0] rd,
                                    logic [CW-1:0] fill, logic [DATA_WIDTH-1:0] front,
                                    logic [DATA_WIDTH-1:0] rear);
        out_t r;
        r.status      = status;
        r.read_value  = rd;
        r.front_value = (fill == '0) ? NEG_ONE : report(front);
        r.rear_value  = (fill == '0) ? NEG_ONE : report(rear);
        r.count       = 9'(fill);
        r.is_empty    = (fill == '0);
        return r;
    endfunction

    logic                  state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] rear_reg, rear_next;
    logic [1:0]            pend_reg, pend_next;
    logic [31:0]           pend_rd_reg, pend_rd_next;
    logic                  done_reg, done_next;
    out_t                  rsp_reg, rsp_next;

    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

    logic                  accept, is_full, is_emp, out_of_range;
    logic [DATA_WIDTH-1:0] word;
    logic [AW-1:0]         addr_head_dec, addr_tail, addr_second, addr_before_last, addr_idx;

    dqe_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign busy   = (state_reg == STATE_WAIT);
    assign accept = start && !busy;
    assign is_full = (fill_reg == CW'(DEPTH));
    assign is_emp  = (fill_reg == '0);
    assign out_of_range = ({24'd0, req.index} >= 32'(fill_reg));
    assign word = store(req.value);

    assign addr_head_dec    = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign addr_tail        = phys(head_reg, fill_reg);
    assign addr_second      = phys(head_reg, CW'(1));
    assign addr_before_last = phys(head_reg, fill_reg - CW'(2));
    assign addr_idx         = phys(head_reg, CW'(req.index));

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        front_next   = front_reg;
        rear_next    = rear_reg;
        pend_next    = pend_reg;
        pend_rd_next = pend_rd_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        mem_we       = 1'b0;
        mem_waddr    = addr_tail;
        mem_wdata    = word;
        mem_re       = 1'b0;
        mem_raddr    = addr_idx;

        if (state_reg == STATE_WAIT)
        begin
            // The fetched word completes the command taken in the cycle before.
            state_next = STATE_IDLE;
            done_next  = 1'b1;
            case (pend_reg)
                PEND_FRONT:
                begin
                    front_next = mem_rdata;
                    rsp_next   = mk_rsp(STATUS_OK, pend_rd_reg, fill_reg, mem_rdata, rear_reg);
                end
                PEND_REAR:
                begin
                    rear_next = mem_rdata;
                    rsp_next  = mk_rsp(STATUS_OK, pend_rd_reg, fill_reg, front_reg, mem_rdata);
                end
                default:
                begin
                    rsp_next = mk_rsp(STATUS_OK, report(mem_rdata), fill_reg, front_reg,
                                      rear_reg);
                end
            endcase
        end
        else if (accept)
        begin
            done_next = 1'b1;
            case (req.op)
                OP_PUSH_FRONT, OP_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        rsp_next = mk_rsp(STATUS_FULL, NEG_ONE, fill_reg, front_reg, rear_reg);
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + CW'(1);
                        if (req.op == OP_PUSH_FRONT)
                        begin
                            mem_waddr  = addr_head_dec;
                            head_next  = addr_head_dec;
                            front_next = word;
                            if (is_emp)
                            begin
                                rear_next = word;
                            end
                        end
                        else
                        begin
                            mem_waddr = addr_tail;
                            rear_next = word;
                            if (is_emp)
                            begin
                                front_next = word;
                            end
                        end
                        rsp_next = mk_rsp(STATUS_OK, report(word), fill_next, front_next,
                                          rear_next);
                    end
                end
                OP_POP_FRONT, OP_POP_REAR:
                begin
                    if (is_emp)
                    begin
                        rsp_next = mk_rsp(STATUS_EMPTY, NEG_ONE, fill_reg, front_reg, rear_reg);
                    end
                    else
                    begin
                        fill_next = fill_reg - CW'(1);
                        if (req.op == OP_POP_FRONT)
                        begin
                            head_next    = addr_second;
                            pend_rd_next = report(front_reg);
                            pend_next    = PEND_FRONT;
                            mem_raddr    = addr_second;
                        end
                        else
                        begin
                            pend_rd_next = report(rear_reg);
                            pend_next    = PEND_REAR;
                            mem_raddr    = addr_before_last;
                        end
                        if (fill_reg == CW'(1))
                        begin
                            rsp_next = mk_rsp(STATUS_OK, pend_rd_next, fill_next, front_reg,
                                              rear_reg);
                        end
                        else
                        begin
                            // The new end element must be fetched before responding.
                            mem_re     = 1'b1;
                            done_next  = 1'b0;
                            state_next = STATE_WAIT;
                        end
                    end
                end
                OP_READ_IDX:
                begin
                    if (out_of_range)
                    begin
                        rsp_next = mk_rsp(STATUS_RANGE, NEG_ONE, fill_reg, front_reg, rear_reg);
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = addr_idx;
                        pend_next  = PEND_READ;
                        done_next  = 1'b0;
                        state_next = STATE_WAIT;
                    end
                end
                OP_WRITE_IDX:
                begin
                    if (out_of_range)
                    begin
                        rsp_next = mk_rsp(STATUS_RANGE, NEG_ONE, fill_reg, front_reg, rear_reg);
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = addr_idx;
                        if (req.index == 8'd0)
                        begin
                            front_next = word;
                        end
                        if (({24'd0, req.index} + 32'd1) == 32'(fill_reg))
                        begin
                            rear_next = word;
                        end
                        rsp_next = mk_rsp(STATUS_OK, report(word), fill_reg, front_next,
                                          rear_next);
                    end
                end
                OP_CLEAR:
                begin
                    fill_next = '0;
                    rsp_next  = mk_rsp(STATUS_OK, 32'd0, '0, front_reg, rear_reg);
                end
                default:
                begin
                    rsp_next = mk_rsp(STATUS_OK, 32'd0, fill_reg, front_reg, rear_reg);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg   <= front_next;
        rear_reg    <= rear_next;
        pend_reg    <= pend_next;
        pend_rd_reg <= pend_rd_next;
        rsp_reg     <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response beat shown while a fetch is pending");

    a_wait_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy && done)
        else $error("fetch wait did not end with a response beat");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count exceeds depth");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.is_empty |-> rsp.front_value == NEG_ONE && rsp.rear_value == NEG_ONE)
        else $error("empty queue reports an end element");

endmodule

`default_nettype wire
